// ===== sv/mfes_pkg.sv =====
// Shared types, codes and encode helpers for the MIDI file event serializer.
`default_nettype none

package mfes_pkg;

    localparam int unsigned REC_BYTES = 14;
    localparam int unsigned REC_W     = REC_BYTES * 8;

    typedef logic [2:0] t_mode;

    localparam t_mode MODE_FILE_HDR  = 3'd0;
    localparam t_mode MODE_TRACK_HDR = 3'd1;
    localparam t_mode MODE_CHAN_EVT  = 3'd2;
    localparam t_mode MODE_META_HDR  = 3'd3;
    localparam t_mode MODE_PAYLOAD   = 3'd4;
    localparam t_mode MODE_EOT       = 3'd5;

    localparam logic CFG_MAX_DELTA = 1'b0;
    localparam logic CFG_DIVISION  = 1'b1;

    localparam logic [27:0] MAX_DELTA_RST = 28'hFFF_FFFF;
    localparam logic [15:0] DIVISION_RST  = 16'd500;

    localparam logic [31:0] FILE_TAG    = "MThd";
    localparam logic [31:0] TRACK_TAG   = "MTrk";
    localparam logic [31:0] FILE_HDR_LEN = 32'd6;
    localparam logic [7:0]  META_STATUS = 8'hFF;
    localparam logic [7:0]  META_EOT    = 8'h2F;
    localparam logic [7:0]  VLQ_CONT    = 8'h80;

    typedef logic [REC_W-1:0] t_rec_bytes;

    // byte 0 of the record goes out first
    typedef struct packed {
        logic [3:0] last_idx;
        t_rec_bytes bytes;
    } t_rec;

    typedef struct packed {
        logic [2:0]  nbytes;
        logic [31:0] bytes;
    } t_vlq;

    typedef struct packed {
        logic push;
    } t_wr_ctl;

    function automatic logic [31:0] byte_rev32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // clamp, then VLQ with the most significant group in byte 0
    function automatic t_vlq vlq_encode(input logic [31:0] v, input logic [27:0] lim);
        logic [27:0] c;
        t_vlq        r;
        c = (v > {4'd0, lim}) ? lim : v[27:0];
        if (c[27:21] != 7'd0) begin
            r.nbytes = 3'd4;
            r.bytes  = {1'b0, c[6:0], VLQ_CONT[7], c[13:7],
                        VLQ_CONT[7], c[20:14], VLQ_CONT[7], c[27:21]};
        end else if (c[20:14] != 7'd0) begin
            r.nbytes = 3'd3;
            r.bytes  = {8'd0, 1'b0, c[6:0], VLQ_CONT[7], c[13:7], VLQ_CONT[7], c[20:14]};
        end else if (c[13:7] != 7'd0) begin
            r.nbytes = 3'd2;
            r.bytes  = {16'd0, 1'b0, c[6:0], VLQ_CONT[7], c[13:7]};
        end else begin
            r.nbytes = 3'd1;
            r.bytes  = {24'd0, 1'b0, c[6:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mfes_front.sv =====
// Front end: config registers, item decode and record assembly.
`default_nettype none

module mfes_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_index,
    input  wire logic [27:0]           i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic [2:0]            i_mode,
    input  wire logic [31:0]           i_delta,
    input  wire logic [7:0]            i_status,
    input  wire logic [7:0]            i_data1,
    input  wire logic [7:0]            i_data2,
    input  wire logic [7:0]            i_meta_type,
    input  wire logic [31:0]           i_length,
    input  wire logic [7:0]            i_payload_byte,
    input  wire logic                  i_full,
    output logic                       o_in_ready,
    output mfes_pkg::t_wr_ctl          o_wr,
    output mfes_pkg::t_rec             o_rec
);

    logic [27:0]       r_max_delta;
    logic [15:0]       r_division;
    mfes_pkg::t_vlq    vd;
    mfes_pkg::t_vlq    vl;
    logic              known;
    logic [2:0]        sh_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_delta <= mfes_pkg::MAX_DELTA_RST;
            r_division  <= mfes_pkg::DIVISION_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mfes_pkg::CFG_MAX_DELTA: r_max_delta <= i_cfg_data;
                mfes_pkg::CFG_DIVISION:  r_division  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign vd     = mfes_pkg::vlq_encode(i_delta, r_max_delta);
    assign vl     = mfes_pkg::vlq_encode(i_length, r_max_delta);
    assign sh_len = 3'(vd.nbytes + 3'd2);

    always_comb begin
        known      = 1'b1;
        o_rec      = '0;
        unique case (i_mode)
            mfes_pkg::MODE_FILE_HDR: begin
                o_rec.last_idx = 4'd13;
                o_rec.bytes    = {r_division[7:0], r_division[15:8], 8'h01, 8'h00,
                                  8'h00, 8'h00,
                                  mfes_pkg::byte_rev32(mfes_pkg::FILE_HDR_LEN),
                                  mfes_pkg::byte_rev32(mfes_pkg::FILE_TAG)};
            end
            mfes_pkg::MODE_TRACK_HDR: begin
                o_rec.last_idx = 4'd7;
                o_rec.bytes    = mfes_pkg::t_rec_bytes'({mfes_pkg::byte_rev32(i_length),
                                  mfes_pkg::byte_rev32(mfes_pkg::TRACK_TAG)});
            end
            mfes_pkg::MODE_CHAN_EVT: begin
                o_rec.last_idx = 4'({1'b0, vd.nbytes} + 4'd2);
                o_rec.bytes    = mfes_pkg::t_rec_bytes'(vd.bytes)
                               | (mfes_pkg::t_rec_bytes'({1'b0, i_data2[6:0], 1'b0,
                                  i_data1[6:0], i_status}) << {vd.nbytes, 3'b000});
            end
            mfes_pkg::MODE_META_HDR: begin
                o_rec.last_idx = 4'({1'b0, vd.nbytes} + {1'b0, vl.nbytes} + 4'd1);
                o_rec.bytes    = mfes_pkg::t_rec_bytes'(vd.bytes)
                               | (mfes_pkg::t_rec_bytes'({i_meta_type,
                                  mfes_pkg::META_STATUS}) << {vd.nbytes, 3'b000})
                               | (mfes_pkg::t_rec_bytes'(vl.bytes) << {sh_len, 3'b000});
            end
            mfes_pkg::MODE_PAYLOAD: begin
                o_rec.last_idx = 4'd0;
                o_rec.bytes    = mfes_pkg::t_rec_bytes'(i_payload_byte);
            end
            mfes_pkg::MODE_EOT: begin
                o_rec.last_idx = 4'd3;
                o_rec.bytes    = mfes_pkg::t_rec_bytes'({8'h00, mfes_pkg::META_EOT,
                                  mfes_pkg::META_STATUS, 8'h00});
            end
            default: known = 1'b0;
        endcase
    end

    // unknown modes are taken and dropped
    assign o_in_ready = !i_full;
    assign o_wr.push  = i_in_valid && known && !i_full;

endmodule

`default_nettype wire

// ===== sv/mfes_queue.sv =====
// Record queue between the front end and the byte serializer.
`default_nettype none

module mfes_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  mfes_pkg::t_wr_ctl      i_wr,
    input  mfes_pkg::t_rec         i_rec,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output mfes_pkg::t_rec         o_rec
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    mfes_pkg::t_rec  r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr.push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : PtrW'(r_wr_ptr + 1'b1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : PtrW'(r_rd_ptr + 1'b1);
        end
        if (i_wr.push && !do_pop) begin
            n_count = CntW'(r_count + 1'b1);
        end else if (!i_wr.push && do_pop) begin
            n_count = CntW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mfes_back.sv =====
// Back end: shifts one record out a byte per beat and flags its last byte.
`default_nettype none

module mfes_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  mfes_pkg::t_rec     i_rec,
    output logic               o_pop,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_last
);

    logic                 r_valid, n_valid;
    logic [3:0]           r_left, n_left;
    mfes_pkg::t_rec_bytes r_bytes, n_bytes;
    logic                 beat;

    assign beat        = r_valid && i_out_ready;
    assign o_pop       = !i_empty && (!r_valid || (beat && r_left == 4'd0));
    assign o_out_valid = r_valid;
    assign o_out_byte  = r_bytes[7:0];
    assign o_last      = (r_left == 4'd0);

    always_comb begin
        n_valid = r_valid;
        n_left  = r_left;
        n_bytes = r_bytes;
        if (o_pop) begin
            n_valid = 1'b1;
            n_left  = i_rec.last_idx;
            n_bytes = i_rec.bytes;
        end else if (beat) begin
            if (r_left == 4'd0) begin
                n_valid = 1'b0;
            end else begin
                n_left  = 4'(r_left - 1'b1);
                n_bytes = r_bytes >> 8;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else begin
            r_valid <= n_valid;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

endmodule

`default_nettype wire

// ===== sv/midi_file_event_serializer_unit.sv =====
// Top level of the Standard MIDI File record serializer.
//
// Input channel (i_in_valid / o_in_ready): one beat asks for one record,
// selected by i_mode. Output channel (o_out_valid / i_out_ready): one beat
// per file byte, o_last high on the final byte of each record.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 max_delta, 1 division); write only while the block is idle.
// Path: with the output side idle, an accepted record is written to the record
// queue, then popped into the output shifter, which raises o_out_valid for it.
// Output: a record of N bytes (1 to 14) leaves as N output beats from the
// one-byte-per-beat output shifter; a channel event is 4 to 7 bytes.
// Inputs keep being taken while the record queue (QUEUE_DEPTH records) has
// room, so decode overlaps byte output. Modes 6 and 7 are taken and dropped.
// Output stall: the current byte holds; once the queue fills, o_in_ready
// drops. Reset empties queue and output and restores max_delta 0x0FFFFFFF
// and division 500.
`default_nettype none

module midi_file_event_serializer_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [27:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_mode,
    input  wire logic [31:0] i_delta,
    input  wire logic [7:0]  i_status,
    input  wire logic [7:0]  i_data1,
    input  wire logic [7:0]  i_data2,
    input  wire logic [7:0]  i_meta_type,
    input  wire logic [31:0] i_length,
    input  wire logic [7:0]  i_payload_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last
);

    mfes_pkg::t_wr_ctl wr;
    mfes_pkg::t_rec    wr_rec;
    mfes_pkg::t_rec    rd_rec;
    logic              full;
    logic              empty;
    logic              pop;

    mfes_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_mode         (i_mode),
        .i_delta        (i_delta),
        .i_status       (i_status),
        .i_data1        (i_data1),
        .i_data2        (i_data2),
        .i_meta_type    (i_meta_type),
        .i_length       (i_length),
        .i_payload_byte (i_payload_byte),
        .i_full         (full),
        .o_in_ready     (o_in_ready),
        .o_wr           (wr),
        .o_rec          (wr_rec)
    );

    mfes_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_rec   (wr_rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_rec   (rd_rec)
    );

    mfes_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_rec       (rd_rec),
        .o_pop       (pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// ===== sv/mfes_checker.sv =====
// Port-level checks for the serializer, bound to the top level.
`default_nettype none

module mfes_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic [2:0] i_mode,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("stalled output beat changed");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // a record has no gaps between its bytes
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid)
        else $error("gap inside a record");

    // an accepted known item shows output once through the record queue and the output shifter
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_mode <= mfes_pkg::MODE_EOT) |-> ##2 o_out_valid)
        else $error("accepted item produced no output");

endmodule

bind midi_file_event_serializer_unit mfes_checker u_mfes_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_mode      (i_mode),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte),
    .o_last      (o_last)
);

`default_nettype wire

// ===== test/mfes_stream_checker.sv =====
// Byte-stream checker for the MIDI file serializer: predicts each record and compares out beats.
`timescale 1ns / 100ps

module mfes_stream_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [27:0]         i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  mfes_pkg::t_mode     i_mode,
    input  logic [31:0]         i_delta,
    input  logic [7:0]          i_status,
    input  logic [7:0]          i_data1,
    input  logic [7:0]          i_data2,
    input  logic [7:0]          i_meta_type,
    input  logic [31:0]         i_length,
    input  logic [7:0]          i_payload_byte,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [7:0]          i_out_byte,
    input  logic                i_last,
    output int                  o_pending,
    output int                  o_errors,
    output int                  o_bytes_checked
);
    import mfes_pkg::*;

    localparam logic [27:0] LIM_RESET   = 28'hFFF_FFFF;
    localparam logic [15:0] TICKS_RESET = 16'd500;
    localparam logic [31:0] HDR_ID      = "MThd";
    localparam logic [31:0] TRK_ID      = "MTrk";
    localparam logic [31:0] HDR_LEN     = 32'd6;
    localparam logic [31:0] FMT0_ONE_TRK = 32'h0000_0001;
    localparam logic [7:0]  META_MARK   = 8'hFF;
    localparam logic [7:0]  EOT_TYPE    = 8'h2F;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_file_byte;

    t_file_byte  file_bytes_q[$];
    logic [7:0]  rec_q[$];
    logic [27:0] lim_q;
    logic [15:0] ticks_q;

    task automatic push_word(input logic [31:0] w);
        for (int b = 3; b >= 0; b--)
            rec_q.push_back(w[8*b +: 8]);
    endtask

    // clamp to the limit, then 7-bit groups, most significant first
    task automatic push_vlq(input logic [31:0] v);
        logic [27:0] c;
        logic [6:0]  grp [4];
        int          n;
        c = (v > {4'd0, lim_q}) ? lim_q : v[27:0];
        n = 0;
        do begin
            grp[n] = c[6:0];
            c = c >> 7;
            n++;
        end while (c != 0 && n < 4);
        for (int k = n - 1; k >= 0; k--)
            rec_q.push_back({(k != 0), grp[k]});
    endtask

    task automatic serialize_record(input t_mode mode, input logic [31:0] delta,
                                    input logic [7:0] status, input logic [7:0] d1,
                                    input logic [7:0] d2, input logic [7:0] mtype,
                                    input logic [31:0] len, input logic [7:0] pbyte);
        rec_q.delete();
        case (mode)
            MODE_FILE_HDR: begin
                push_word(HDR_ID);
                push_word(HDR_LEN);
                push_word(FMT0_ONE_TRK);
                rec_q.push_back(ticks_q[15:8]);
                rec_q.push_back(ticks_q[7:0]);
            end
            MODE_TRACK_HDR: begin
                push_word(TRK_ID);
                push_word(len);
            end
            MODE_CHAN_EVT: begin
                push_vlq(delta);
                rec_q.push_back(status);
                rec_q.push_back({1'b0, d1[6:0]});
                rec_q.push_back({1'b0, d2[6:0]});
            end
            MODE_META_HDR: begin
                push_vlq(delta);
                rec_q.push_back(META_MARK);
                rec_q.push_back(mtype);
                push_vlq(len);
            end
            MODE_PAYLOAD: begin
                rec_q.push_back(pbyte);
            end
            MODE_EOT: begin
                rec_q.push_back(8'h00);
                rec_q.push_back(META_MARK);
                rec_q.push_back(EOT_TYPE);
                rec_q.push_back(8'h00);
            end
            default: ;
        endcase
        for (int k = 0; k < rec_q.size(); k++)
            file_bytes_q.push_back('{data: rec_q[k], last: (k == rec_q.size() - 1)});
    endtask

    always @(posedge i_clk) begin
        t_file_byte want;
        if (!i_rst_n) begin
            file_bytes_q.delete();
            lim_q <= LIM_RESET;
            ticks_q <= TICKS_RESET;
            o_errors = 0;
            o_bytes_checked = 0;
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (file_bytes_q.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, actual byte %h last %b",
                             $time, i_out_byte, i_last);
                    o_errors++;
                end else begin
                    want = file_bytes_q.pop_front();
                    o_bytes_checked++;
                    if (i_out_byte !== want.data) begin
                        $display("%0t: out_byte mismatch: expected %h, actual %h",
                                 $time, want.data, i_out_byte);
                        o_errors++;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last mismatch: expected %b, actual %b (byte %h)",
                                 $time, want.last, i_last, i_out_byte);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                serialize_record(i_mode, i_delta, i_status, i_data1, i_data2,
                                 i_meta_type, i_length, i_payload_byte);
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_DELTA)
                    lim_q <= i_cfg_data;
                else
                    ticks_q <= i_cfg_data[15:0];
            end
            o_pending <= file_bytes_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the MIDI file serializer: record stimulus, register phases and verdict.
`timescale 1ns / 100ps

module tb;
    import mfes_pkg::*;

    localparam t_mode       MODE_SPARE_6 = 3'd6;
    localparam t_mode       MODE_SPARE_7 = 3'd7;
    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam int          DRAIN_CYCLES = 16;
    localparam logic [27:0] LIM_FULL     = 28'hFFF_FFFF;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] delta;
        logic [7:0]  status;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [7:0]  meta_type;
        logic [31:0] len;
        logic [7:0]  payload;
    } t_event_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [27:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_mode       i_mode = MODE_FILE_HDR;
    logic [31:0] i_delta = '0;
    logic [7:0]  i_status = '0;
    logic [7:0]  i_data1 = '0;
    logic [7:0]  i_data2 = '0;
    logic [7:0]  i_meta_type = '0;
    logic [31:0] i_length = '0;
    logic [7:0]  i_payload_byte = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last;

    int          pending_bytes;
    int          fail_count;
    int          bytes_checked;
    int          records_sent = 0;
    int          settings_used = 1;
    int          cycle_count = 0;
    logic [27:0] cur_lim = LIM_FULL;

    midi_file_event_serializer_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_delta        (i_delta),
        .i_status       (i_status),
        .i_data1        (i_data1),
        .i_data2        (i_data2),
        .i_meta_type    (i_meta_type),
        .i_length       (i_length),
        .i_payload_byte (i_payload_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last)
    );

    mfes_stream_checker stream_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_delta         (i_delta),
        .i_status        (i_status),
        .i_data1         (i_data1),
        .i_data2         (i_data2),
        .i_meta_type     (i_meta_type),
        .i_length        (i_length),
        .i_payload_byte  (i_payload_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_byte      (o_out_byte),
        .i_last          (o_last),
        .o_pending       (pending_bytes),
        .o_errors        (fail_count),
        .o_bytes_checked (bytes_checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still pending",
                     cycle_count, pending_bytes);
            $display("[midi_file_event_serializer_unit] ERROR");
            $finish;
        end
    end

    // receiver: runs of ready, then mostly short and now and then long stalls
    initial begin
        int n;
        forever begin
            n = $urandom_range(1, 40);
            repeat (n) begin
                @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            repeat (n) begin
                @(posedge i_clk);
                i_out_ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    function automatic t_event_req mk(input t_mode m, input logic [31:0] delta,
                                      input logic [7:0] status, input logic [7:0] d1,
                                      input logic [7:0] d2, input logic [7:0] mtype,
                                      input logic [31:0] len, input logic [7:0] pb);
        t_event_req r;
        r = '{mode: m, delta: delta, status: status, data1: d1, data2: d2,
              meta_type: mtype, len: len, payload: pb};
        return r;
    endfunction

    // spans every VLQ size, the limit neighborhood and 32-bit overflow
    function automatic logic [31:0] vlq_value(input logic [27:0] lim);
        logic [31:0] corner [10];
        corner = '{32'd0, 32'd127, 32'd128, 32'd16383, 32'd16384, 32'd2097151,
                   32'd2097152, 32'h0FFF_FFFF, 32'h1000_0000, 32'hFFFF_FFFF};
        case ($urandom_range(0, 6))
            0: return $urandom_range(0, 127);
            1: return $urandom_range(128, 16383);
            2: return $urandom_range(16384, 2097151);
            3: return $urandom_range(2097152, 28'hFFF_FFFF);
            4: return $urandom;
            5: return {4'd0, lim} + $urandom_range(0, 2) - 1;
            default: return corner[$urandom_range(0, 9)];
        endcase
    endfunction

    function automatic t_event_req rand_req(input t_mode m);
        t_event_req r;
        r.mode      = m;
        r.delta     = vlq_value(cur_lim);
        r.status    = $urandom;
        r.data1     = $urandom;
        r.data2     = $urandom;
        r.meta_type = $urandom;
        r.len       = (m == MODE_TRACK_HDR) ? $urandom : vlq_value(cur_lim);
        r.payload   = $urandom;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(input t_event_req r);
        i_in_valid     <= 1'b1;
        i_mode         <= r.mode;
        i_delta        <= r.delta;
        i_status       <= r.status;
        i_data1        <= r.data1;
        i_data2        <= r.data2;
        i_meta_type    <= r.meta_type;
        i_length       <= r.len;
        i_payload_byte <= r.payload;
        do @(posedge i_clk); while (!o_in_ready);
        if (r.mode <= MODE_EOT)
            records_sent++;
    endtask

    task automatic pace(input t_event_req r, input bit no_gaps);
        int n;
        n = no_gaps ? 0 : pick_gap();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        send(r);
    endtask

    // hold the sender until every predicted byte is out, then let dropped items settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [27:0] lim, input logic [15:0] ticks);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAX_DELTA;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        i_cfg_index <= CFG_DIVISION;
        i_cfg_data  <= {12'd0, ticks};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_lim = lim;
        settings_used++;
    endtask

    // optional file header, track, events with meta runs, end of track
    task automatic song_track();
        bit         fast;
        int         n_ev;
        int         n_pay;
        t_event_req r;
        fast = ($urandom_range(0, 3) == 0);
        n_ev = $urandom_range(1, 12);
        if ($urandom_range(0, 1))
            pace(rand_req(MODE_FILE_HDR), fast);
        pace(rand_req(MODE_TRACK_HDR), fast);
        repeat (n_ev) begin
            if ($urandom_range(0, 3) == 0) begin
                r = rand_req(MODE_META_HDR);
                if ($urandom_range(0, 2) != 0)
                    r.len = $urandom_range(0, 5);
                pace(r, fast);
                n_pay = (r.len <= 5) ? r.len : $urandom_range(0, 3);
                repeat (n_pay) pace(rand_req(MODE_PAYLOAD), fast);
            end else begin
                pace(rand_req(MODE_CHAN_EVT), fast);
            end
        end
        pace(rand_req(MODE_EOT), fast);
    endtask

    task automatic random_phase(input int n_items);
        int start;
        start = records_sent;
        while (records_sent - start < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6)) pace(rand_req(t_mode'($urandom_range(0, 7))), 1'b0);
            end else begin
                song_track();
            end
            if ($urandom_range(0, 9) == 0)
                drain();
        end
    endtask

    task automatic directed_records();
        pace(mk(MODE_FILE_HDR, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0, 8'h00), 1'b0);
        pace(mk(MODE_TRACK_HDR, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, 8'h00), 1'b0);
        pace(mk(MODE_TRACK_HDR, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd0, 8'hFF), 1'b0);
        pace(mk(MODE_CHAN_EVT, 32'd0, 8'h00, 8'hFF, 8'hFF, 8'h00, 32'd0, 8'h00), 1'b0);
        // saturates at the reset limit
        pace(mk(MODE_CHAN_EVT, 32'hFFFF_FFFF, 8'hFF, 8'h80, 8'h7F, 8'h00, 32'd0, 8'h00), 1'b0);
        pace(mk(MODE_CHAN_EVT, 32'd127, 8'h90, 8'h3C, 8'h40, 8'h00, 32'd0, 8'h00), 1'b0);
        pace(mk(MODE_CHAN_EVT, 32'd128, 8'h80, 8'h3C, 8'h00, 8'h00, 32'd0, 8'h00), 1'b0);
        pace(mk(MODE_CHAN_EVT, 32'd16383, 8'hB0, 8'h07, 8'h64, 8'h00, 32'd0, 8'h00), 1'b0);
        pace(mk(MODE_CHAN_EVT, 32'd16384, 8'hC0, 8'h05, 8'h00, 8'h00, 32'd0, 8'h00), 1'b0);
        pace(mk(MODE_CHAN_EVT, 32'd2097151, 8'hE0, 8'h00, 8'h40, 8'h00, 32'd0, 8'h00), 1'b0);
        pace(mk(MODE_CHAN_EVT, 32'd2097152, 8'h9F, 8'h7F, 8'h7F, 8'h00, 32'd0, 8'h00), 1'b0);
        pace(mk(MODE_CHAN_EVT, 32'h0FFF_FFFF, 8'hA0, 8'h01, 8'h02, 8'h00, 32'd0, 8'h00), 1'b0);
        pace(mk(MODE_CHAN_EVT, 32'h1000_0000, 8'hD0, 8'h55, 8'hAA, 8'h00, 32'd0, 8'h00), 1'b0);
        pace(mk(MODE_META_HDR, 32'd0, 8'h00, 8'h00, 8'h00, 8'hFF, 32'hFFFF_FFFF, 8'h00), 1'b0);
        pace(mk(MODE_META_HDR, 32'h0FFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00, 32'd3, 8'h00), 1'b0);
        pace(mk(MODE_PAYLOAD, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0, 8'h00), 1'b0);
        pace(mk(MODE_PAYLOAD, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0, 8'hFF), 1'b0);
        pace(mk(MODE_PAYLOAD, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0, 8'h55), 1'b0);
        pace(mk(MODE_EOT, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0, 8'h00), 1'b0);
        pace(rand_req(MODE_SPARE_6), 1'b0);
        pace(rand_req(MODE_SPARE_7), 1'b0);
        pace(mk(MODE_PAYLOAD, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0, 8'hA5), 1'b0);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_records();
        random_phase(60);
        drain();
        program_regs(28'd0, 16'd0);
        random_phase(70);
        drain();
        program_regs(LIM_FULL, 16'hFFFF);
        random_phase(70);
        drain();
        program_regs(28'd127, 16'($urandom));
        random_phase(70);
        drain();
        program_regs(28'd16384, 16'd1);
        random_phase(70);
        drain();
        program_regs(28'($urandom), 16'($urandom));
        random_phase(70);
        drain();

        $display("Sent %0d records over %0d register settings; %0d output beats checked.",
                 records_sent, settings_used, bytes_checked);
        $display("Covered zero and full VLQ limits, division extremes and the unused modes.");
        if (fail_count == 0)
            $display("[midi_file_event_serializer_unit] OK");
        else
            $display("[midi_file_event_serializer_unit] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/mfes_pkg.sv
sv/mfes_front.sv
sv/mfes_queue.sv
sv/mfes_back.sv
sv/midi_file_event_serializer_unit.sv
sv/mfes_checker.sv
test/mfes_stream_checker.sv
test/tb.sv
